/* sv/lru_page_replacement_macros.svh */
// Assertion macros shared by the LRU page replacement checker
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define LPR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lpr checker: same-cycle rule violated");

// Next-cycle implication, sampled on the rising clock, off during reset
`define LPR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lpr checker: next-cycle rule violated");

`endif

/* sv/lpr_pkg.sv */
// Package for the LRU page replacement block: constants and shared types
package lpr_pkg;

    // Build defaults
    localparam int LPR_MAX_FRAMES = 8;
    localparam int LPR_PAGE_BITS  = 8;

    // Fixed field widths of the interface
    localparam int CFG_W         = 4;
    localparam int DEPTH_FIELD_W = 3;
    localparam int OCC_FIELD_W   = 4;
    localparam int FAULT_W       = 16;

    localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

    // Per-cell control for one lookup
    typedef struct packed {
        logic load;    // a transaction is accepted this cycle
        logic active;  // cell sits below the frame limit
        logic last;    // cell is the bottom frame in use
        logic hit;     // some cell matched the reference
    } t_cell_ctl;

endpackage

/* sv/lpr_cell.sv */
// One frame of the recency stack: holds a page, compares, shifts from its upper neighbor
module lpr_cell #(
    parameter int PAGE_BITS = lpr_pkg::LPR_PAGE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lpr_pkg::t_cell_ctl    i_ctl,
    input  logic [PAGE_BITS-1:0]  i_page_ref,
    input  logic [PAGE_BITS-1:0]  i_prev_page,
    input  logic                  i_prev_valid,
    input  logic                  i_found,
    output logic [PAGE_BITS-1:0]  o_page,
    output logic                  o_valid,
    output logic                  o_found,
    output logic                  o_first,
    output logic [PAGE_BITS-1:0]  o_ev_page
);
    import lpr_pkg::*;

    logic [PAGE_BITS-1:0] r_page;
    logic [PAGE_BITS-1:0] n_page;
    logic                 r_valid;
    logic                 n_valid;
    logic                 valid_eff;
    logic                 match;
    logic                 shift;

    // Entries past the frame limit count as empty
    assign valid_eff = r_valid & i_ctl.active;
    assign match     = valid_eff && (r_page == i_page_ref);

    // Prefix chain: first match wins
    assign o_found = i_found | match;
    assign o_first = match & ~i_found;

    // Hit: cells down to the hit slot shift; miss: shift down the filled prefix
    assign shift = i_ctl.hit ? ~i_found : (i_prev_valid & i_ctl.active);

    assign o_page    = r_page;
    assign o_valid   = valid_eff;
    assign o_ev_page = (i_ctl.last && r_valid) ? r_page : '0;

    // Next state
    always_comb begin
        n_page  = r_page;
        n_valid = r_valid;
        if (i_ctl.load) begin
            if (!i_ctl.active) begin
                n_page  = '0;
                n_valid = 1'b0;
            end else if (shift) begin
                n_page  = i_prev_page;
                n_valid = i_prev_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_page  <= n_page;
            r_valid <= n_valid;
        end
    end

endmodule

/* sv/lru_page_replacement.sv */
// A result is registered: it is valid in the cycle after its reference is accepted.
// Throughput: one reference per cycle while results are taken; the cell chain
//   compares and shifts all frames in the accepting cycle.
// A waiting result holds in the output register and blocks the next reference.
// Reset (synchronous, active low) empties all frames, clears the fault counter
//   and sets the frame limit to MAX_FRAMES.
module lru_page_replacement #(
    parameter int MAX_FRAMES = lpr_pkg::LPR_MAX_FRAMES,
    parameter int PAGE_BITS  = lpr_pkg::LPR_PAGE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lpr_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [PAGE_BITS-1:0]              i_page,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_hit,
    output logic [lpr_pkg::DEPTH_FIELD_W-1:0] o_hit_depth,
    output logic                              o_evicted_valid,
    output logic [PAGE_BITS-1:0]              o_evicted_page,
    output logic [lpr_pkg::OCC_FIELD_W-1:0]   o_occupancy,
    output logic [lpr_pkg::FAULT_W-1:0]       o_fault_count
);
    import lpr_pkg::*;

    localparam int DW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int OW = $clog2(MAX_FRAMES + 1);

    // Configuration and bookkeeping
    logic [OW-1:0]      r_limit;
    logic [OW-1:0]      r_occ;
    logic [OW-1:0]      n_occ;
    logic [FAULT_W-1:0] r_fault;
    logic [FAULT_W-1:0] n_fault;

    // Output register
    logic                     r_out_valid;
    logic                     r_hit;
    logic [DEPTH_FIELD_W-1:0] r_depth;
    logic                     r_ev_valid;
    logic [PAGE_BITS-1:0]     r_ev_page;
    logic [OCC_FIELD_W-1:0]   r_occ_out;

    // Cell chain wiring
    logic [MAX_FRAMES-1:0] w_valid;
    logic [MAX_FRAMES-1:0] w_found;
    logic [MAX_FRAMES-1:0] w_first;
    logic [PAGE_BITS-1:0]  w_page [MAX_FRAMES];
    logic [PAGE_BITS-1:0]  w_ev   [MAX_FRAMES];
    t_cell_ctl             w_ctl  [MAX_FRAMES];

    logic                 accept;
    logic                 hit;
    logic [DW-1:0]        depth;
    logic [OW-1:0]        occ_eff;
    logic                 full;
    logic                 ev_valid;
    logic [PAGE_BITS-1:0] ev_or;

    assign o_in_ready = ~r_out_valid | i_out_ready;
    assign accept     = i_in_valid & o_in_ready;
    assign hit        = w_found[MAX_FRAMES-1];

    // Cell chain
    for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
        assign w_ctl[g].load   = accept;
        assign w_ctl[g].active = OW'(g) < r_limit;
        assign w_ctl[g].last   = OW'(g + 1) == r_limit;
        assign w_ctl[g].hit    = hit;
        if (g == 0) begin : g_top
            lpr_cell #(.PAGE_BITS(PAGE_BITS)) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl[g]),
                .i_page_ref   (i_page),
                .i_prev_page  (i_page),
                .i_prev_valid (1'b1),
                .i_found      (1'b0),
                .o_page       (w_page[g]),
                .o_valid      (w_valid[g]),
                .o_found      (w_found[g]),
                .o_first      (w_first[g]),
                .o_ev_page    (w_ev[g])
            );
        end else begin : g_rest
            lpr_cell #(.PAGE_BITS(PAGE_BITS)) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl[g]),
                .i_page_ref   (i_page),
                .i_prev_page  (w_page[g-1]),
                .i_prev_valid (w_valid[g-1]),
                .i_found      (w_found[g-1]),
                .o_page       (w_page[g]),
                .o_valid      (w_valid[g]),
                .o_found      (w_found[g]),
                .o_first      (w_first[g]),
                .o_ev_page    (w_ev[g])
            );
        end
    end

    // Hit depth and bottom page, one-hot OR over the cells
    always_comb begin
        depth = '0;
        ev_or = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (w_first[i]) begin
                depth = depth | DW'(i);
            end
            ev_or = ev_or | w_ev[i];
        end
    end

    // Occupancy, capped by the current frame limit
    assign occ_eff  = (r_occ > r_limit) ? r_limit : r_occ;
    assign full     = occ_eff >= r_limit;
    assign ev_valid = ~hit & full;

    always_comb begin
        if (hit) begin
            n_occ = occ_eff;
        end else if (full) begin
            n_occ = r_limit;
        end else begin
            n_occ = occ_eff + OW'(1);
        end
    end

    // Saturating fault counter
    always_comb begin
        n_fault = r_fault;
        if (!hit && r_fault != FAULT_MAX) begin
            n_fault = r_fault + FAULT_W'(1);
        end
    end

    // Frame limit register, clamped on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= OW'(MAX_FRAMES);
        end else if (i_cfg_we) begin
            if (i_cfg_data == '0) begin
                r_limit <= OW'(1);
            end else if (int'(i_cfg_data) > MAX_FRAMES) begin
                r_limit <= OW'(MAX_FRAMES);
            end else begin
                r_limit <= OW'(i_cfg_data);
            end
        end
    end

    // State updated per accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ   <= '0;
            r_fault <= '0;
        end else if (accept) begin
            r_occ   <= n_occ;
            r_fault <= n_fault;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hit      <= hit;
            r_depth    <= hit ? DEPTH_FIELD_W'(depth) : '0;
            r_ev_valid <= ev_valid;
            r_ev_page  <= ev_valid ? ev_or : '0;
            r_occ_out  <= OCC_FIELD_W'(n_occ);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_hit;
    assign o_hit_depth     = r_depth;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = r_ev_page;
    assign o_occupancy     = r_occ_out;
    assign o_fault_count   = r_fault;

endmodule

/* sv/lpr_checker.sv */
// Port-level checker for the LRU page replacement block, bound to the top level
`include "lru_page_replacement_macros.svh"

module lpr_checker #(
    parameter int PAGE_BITS = lpr_pkg::LPR_PAGE_BITS
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic                              o_hit,
    input logic [lpr_pkg::DEPTH_FIELD_W-1:0] o_hit_depth,
    input logic                              o_evicted_valid,
    input logic [PAGE_BITS-1:0]              o_evicted_page,
    input logic [lpr_pkg::OCC_FIELD_W-1:0]   o_occupancy,
    input logic [lpr_pkg::FAULT_W-1:0]       o_fault_count
);
    import lpr_pkg::*;

    // A hit never evicts and always leaves a resident page
    `LPR_ASSERT_NOW(a_hit_no_evict, o_out_valid && o_hit, !o_evicted_valid && o_occupancy != '0)

    // A fault reports depth zero; no eviction reports page zero
    `LPR_ASSERT_NOW(a_fault_fields, o_out_valid && !o_hit, o_hit_depth == '0)
    `LPR_ASSERT_NOW(a_no_evict_zero, o_out_valid && !o_evicted_valid, o_evicted_page == '0)

    // A stalled transaction holds
    `LPR_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_fault_count) && $stable(o_evicted_page))

endmodule

bind lru_page_replacement lpr_checker #(.PAGE_BITS(PAGE_BITS)) u_lpr_checker (.*);
